// ===== hw/rtl/sro_pkg.sv =====
package sro_pkg;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned MAX_RESULTS = 33;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned DISP_W = 3;
  localparam int unsigned IDX_W  = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int unsigned DATA_W = ((SEQ_W + LEN_W + 7) / 8) * 8;

  typedef enum logic [DISP_W-1:0] {
    DISP_NOW       = 3'd0,
    DISP_RELEASED  = 3'd1,
    DISP_STORED    = 3'd2,
    DISP_LATE      = 3'd3,
    DISP_DUPLICATE = 3'd4,
    DISP_EMPTY     = 3'd5
  } disp_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  // One access to the store; indexes are logical, counted from the head.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } store_req_t;

endpackage

// ===== hw/rtl/sro_store.sv =====
module sro_store (
  input  logic                      clk_i,
  input  logic [sro_pkg::IDX_W-1:0] head_i,
  input  sro_pkg::store_req_t       req_i,
  output sro_pkg::entry_t           rd_data_o
);
  import sro_pkg::*;

  entry_t mem_q [STORE_DEPTH];

  // Map a logical index onto the ring that starts at the head.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (IDX_W+1)'(STORE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(STORE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[phys(head_i, req_i.wr_idx)] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[phys(head_i, req_i.rd_idx)];
    end
  end

endmodule

// ===== hw/rtl/sequence_reorder_buffer.sv =====
// Packet reorder buffer. Each input word is a descriptor {payload length,
// sequence}; the block answers with one or more result words, the first
// describing the input itself (delivered now, stored, dropped late,
// dropped duplicate or dropped empty) and any further ones releasing
// stored descriptors that have come into order; tlast marks the final word
// for the input. Sequence order is serial arithmetic modulo 2^32. Early
// descriptors sit sorted in a ring held in one single-port-write,
// registered-read memory; an insertion walks from the tail toward the head,
// moving one entry up per cycle, and a release reads the head and then
// checks it, waiting while the output is stalled. A duplicate found below
// entries already moved up is followed by a walk that moves those entries
// back down, one per cycle. When an insertion fills the store, the
// expected number jumps to the oldest stored sequence. One descriptor is
// handled at a time, and the output can stall it wherever a word is
// pushed. The input is taken again only when the previous descriptor's
// last word is registered.
module sequence_reorder_buffer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // tdata: seq_number[31:0], payload_length[47:32]
  input  logic [sro_pkg::DATA_W-1:0] s_axis_tdata_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata: out_seq[31:0], out_length[47:32]
  output logic [sro_pkg::DATA_W-1:0] m_axis_tdata_o,
  // tuser: disposition[2:0]
  output logic [sro_pkg::DISP_W-1:0] m_axis_tuser_o,
  // tlast: last_result
  output logic                       m_axis_tlast_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i
);
  import sro_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_REL_RD,
    ST_REL_CHK,
    ST_DONE,
    ST_UNDO
  } state_e;

  state_e           state_q;
  logic [SEQ_W-1:0] exp_q;      // next sequence to deliver
  logic [IDX_W-1:0] head_q;     // ring position of the oldest entry
  logic [CNT_W-1:0] cnt_q;      // stored entries
  logic [IDX_W-1:0] idx_q;      // logical index under compare while inserting
  entry_t           new_q;      // descriptor being inserted
  logic [SEQ_W-1:0] off_q;      // its serial offset from exp_q
  logic             jump_q;     // store just filled: head is taken as expected
  logic [RES_W-1:0] res_cnt_q;  // results produced for this input so far
  disp_e            pend_disp_q;
  entry_t           pend_q;     // result held until we know whether it is last

  logic             out_valid_q;
  disp_e            out_disp_q;
  entry_t           out_q;
  logic             out_last_q;

  store_req_t       req;
  entry_t           rd_data;

  entry_t           in_entry;
  logic [SEQ_W-1:0] in_off;
  logic             in_acc;
  logic             in_late;
  logic [SEQ_W-1:0] rd_off;
  logic             ins_dup;
  logic             ins_shift;
  logic             ins_undo;
  logic             undo_more;
  logic             out_free;
  logic             out_push;
  logic             rel_match;
  logic             rel_go;
  logic [CNT_W-1:0] cnt_inc;

  assign in_entry  = entry_t'(s_axis_tdata_i[SEQ_W+LEN_W-1:0]);
  assign in_off    = in_entry.seq - exp_q;
  assign in_late   = in_off[SEQ_W-1];
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_off    = rd_data.seq - exp_q;
  assign ins_dup   = (rd_off == off_q);
  assign ins_shift = (rd_off > off_q);
  // Entries above idx_q+1 were moved up before the duplicate showed up.
  assign ins_undo  = (CNT_W'(idx_q) + CNT_W'(3)) <= cnt_q;
  assign undo_more = (CNT_W'(idx_q) + CNT_W'(2)) <= cnt_q;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign rel_match = jump_q || (rd_data.seq == exp_q);
  assign rel_go    = (cnt_q != '0) && (res_cnt_q < RES_W'(MAX_RESULTS));
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign out_push  = out_free &&
                     (((state_q == ST_REL_CHK) && rel_match) || (state_q == ST_DONE));

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Store accesses: insertion walks down from the tail, moving an entry up
  // one slot in the same cycle that the next lower one is read.
  always_comb begin
    req = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_entry.len != '0) && (in_entry.seq != exp_q) && !in_late) begin
          if (cnt_q == '0) begin
            req.wr_en   = 1'b1;
            req.wr_idx  = '0;
            req.wr_data = in_entry;
          end else begin
            req.rd_en  = 1'b1;
            req.rd_idx = IDX_W'(cnt_q - CNT_W'(1));
          end
        end
      end
      ST_INS: begin
        if (!ins_dup) begin
          req.wr_en   = 1'b1;
          req.wr_idx  = idx_q + IDX_W'(1);
          req.wr_data = ins_shift ? rd_data : new_q;
          if (ins_shift && (idx_q != '0)) begin
            req.rd_en  = 1'b1;
            req.rd_idx = idx_q - IDX_W'(1);
          end
        end else if (ins_undo) begin
          req.rd_en  = 1'b1;
          req.rd_idx = idx_q + IDX_W'(3);
        end
      end
      ST_PUT: begin
        req.wr_en   = 1'b1;
        req.wr_idx  = '0;
        req.wr_data = new_q;
      end
      ST_UNDO: begin
        // Move the entry one slot down and fetch the one above it.
        req.wr_en   = 1'b1;
        req.wr_idx  = idx_q;
        req.wr_data = rd_data;
        if (undo_more) begin
          req.rd_en  = 1'b1;
          req.rd_idx = idx_q + IDX_W'(2);
        end
      end
      ST_REL_RD: begin
        req.rd_en  = rel_go;
        req.rd_idx = '0;
      end
      ST_REL_CHK,
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  sro_store u_store (
    .clk_i    (clk_i),
    .head_i   (head_q),
    .req_i    (req),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exp_q       <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      new_q       <= '0;
      off_q       <= '0;
      jump_q      <= 1'b0;
      res_cnt_q   <= '0;
      pend_disp_q <= DISP_NOW;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      out_disp_q  <= DISP_NOW;
      out_q       <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // Drop the output word once taken; a push holds it valid.
      out_valid_q <= out_push || (out_valid_q && !m_axis_tready_i);
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            new_q     <= in_entry;
            off_q     <= in_off;
            res_cnt_q <= RES_W'(1);
            pend_q    <= in_entry;
            if (in_entry.len == '0) begin
              pend_disp_q <= DISP_EMPTY;
              jump_q      <= 1'b0;
              state_q     <= ST_REL_RD;
            end else if (in_entry.seq == exp_q) begin
              pend_disp_q <= DISP_NOW;
              exp_q       <= exp_q + SEQ_W'(1);
              jump_q      <= 1'b0;
              state_q     <= ST_REL_RD;
            end else if (in_late) begin
              pend_disp_q <= DISP_LATE;
              jump_q      <= 1'b0;
              state_q     <= ST_REL_RD;
            end else if (cnt_q == '0) begin
              pend_disp_q <= DISP_STORED;
              cnt_q       <= cnt_inc;
              jump_q      <= (cnt_inc == CNT_W'(STORE_DEPTH));
              state_q     <= ST_REL_RD;
            end else begin
              idx_q   <= IDX_W'(cnt_q - CNT_W'(1));
              jump_q  <= 1'b0;
              state_q <= ST_INS;
            end
          end
        end
        ST_INS: begin
          if (ins_dup) begin
            pend_disp_q <= DISP_DUPLICATE;
            if (ins_undo) begin
              idx_q   <= idx_q + IDX_W'(2);
              state_q <= ST_UNDO;
            end else begin
              state_q <= ST_REL_RD;
            end
          end else if (ins_shift) begin
            if (idx_q == '0) begin
              state_q <= ST_PUT;
            end else begin
              idx_q <= idx_q - IDX_W'(1);
            end
          end else begin
            pend_disp_q <= DISP_STORED;
            cnt_q       <= cnt_inc;
            jump_q      <= (cnt_inc == CNT_W'(STORE_DEPTH));
            state_q     <= ST_REL_RD;
          end
        end
        ST_PUT: begin
          pend_disp_q <= DISP_STORED;
          cnt_q       <= cnt_inc;
          jump_q      <= (cnt_inc == CNT_W'(STORE_DEPTH));
          state_q     <= ST_REL_RD;
        end
        ST_UNDO: begin
          if (undo_more) begin
            idx_q <= idx_q + IDX_W'(1);
          end else begin
            state_q <= ST_REL_RD;
          end
        end
        ST_REL_RD: begin
          state_q <= rel_go ? ST_REL_CHK : ST_DONE;
        end
        ST_REL_CHK: begin
          if (!rel_match) begin
            state_q <= ST_DONE;
          end else if (out_free) begin
            // Push the held result, then hold the release in its place.
            out_disp_q  <= pend_disp_q;
            out_q       <= pend_q;
            out_last_q  <= 1'b0;
            pend_disp_q <= DISP_RELEASED;
            pend_q      <= rd_data;
            exp_q       <= rd_data.seq + SEQ_W'(1);
            head_q      <= (head_q == IDX_W'(STORE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
            cnt_q       <= cnt_q - CNT_W'(1);
            jump_q      <= 1'b0;
            res_cnt_q   <= res_cnt_q + RES_W'(1);
            state_q     <= ST_REL_RD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_disp_q  <= pend_disp_q;
            out_q       <= pend_q;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_disp_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = DATA_W'(out_q);

  // The store never holds more entries than it has slots.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STORE_DEPTH))
    else $error("entry count above store depth");

  // The ring head wraps before it passes the last slot.
  a_head_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= IDX_W'(STORE_DEPTH - 1))
    else $error("head pointer out of range");

  // No input ever causes more results than the release bound allows.
  a_res_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= RES_W'(MAX_RESULTS))
    else $error("too many results for one input");

  // When ready for a new input, any word still waiting is a final one.
  a_idle_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready_o && m_axis_tvalid_o) |-> m_axis_tlast_o)
    else $error("non-final word pending while idle");

endmodule
